[design/mck_pkg.sv]
// shared types, constants and code tables for the morse character keyer
package mck_pkg;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_SPACE,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  code;
  } entry_t;

  localparam logic [7:0] CODE_END   = 8'h80;
  localparam logic [2:0] DASH_UNITS = 3'd3;
  localparam logic [2:0] DOT_UNITS  = 3'd1;
  localparam logic [2:0] ELEM_GAP   = 3'd2;
  localparam logic [2:0] CHAR_GAP   = 3'd5;
  localparam logic [2:0] WORD_GAP   = 3'd7;
  localparam logic [2:0] OTHER_GAP  = 3'd3;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_LOW_A = 8'h61;
  localparam logic [7:0] ASCII_LOW_Z = 8'h7a;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  function automatic logic [7:0] digit_code(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'hfc;
      4'd1:    c = 8'h7c;
      4'd2:    c = 8'h3c;
      4'd3:    c = 8'h1c;
      4'd4:    c = 8'h0c;
      4'd5:    c = 8'h04;
      4'd6:    c = 8'h84;
      4'd7:    c = 8'hc4;
      4'd8:    c = 8'he4;
      4'd9:    c = 8'hf4;
      default: c = 8'hfc;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = 8'h60;
      5'd1:    c = 8'h88;
      5'd2:    c = 8'ha8;
      5'd3:    c = 8'h90;
      5'd4:    c = 8'h40;
      5'd5:    c = 8'h28;
      5'd6:    c = 8'hd0;
      5'd7:    c = 8'h08;
      5'd8:    c = 8'h20;
      5'd9:    c = 8'h78;
      5'd10:   c = 8'hb0;
      5'd11:   c = 8'h48;
      5'd12:   c = 8'he0;
      5'd13:   c = 8'ha0;
      5'd14:   c = 8'hf0;
      5'd15:   c = 8'h68;
      5'd16:   c = 8'hd8;
      5'd17:   c = 8'h50;
      5'd18:   c = 8'h10;
      5'd19:   c = 8'hc0;
      5'd20:   c = 8'h30;
      5'd21:   c = 8'h18;
      5'd22:   c = 8'h70;
      5'd23:   c = 8'h98;
      5'd24:   c = 8'hb8;
      5'd25:   c = 8'hc8;
      default: c = 8'h60;
    endcase
    return c;
  endfunction

endpackage

[design/mck_front.sv]
// front end: classifies an incoming character and looks up its code byte
module mck_front (
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] character
  input  logic           q_ready,
  output logic           q_push,
  output mck_pkg::entry_t q_entry
);

  logic [7:0] digit_off;
  logic [7:0] letter_off;

  assign digit_off  = in_tdata - mck_pkg::ASCII_ZERO;
  assign letter_off = in_tdata - mck_pkg::ASCII_LOW_A;

  always_comb begin
    q_entry.kind = mck_pkg::KIND_OTHER;
    q_entry.code = mck_pkg::CODE_END;
    if (in_tdata >= mck_pkg::ASCII_ZERO && in_tdata <= mck_pkg::ASCII_NINE) begin
      q_entry.kind = mck_pkg::KIND_CODE;
      q_entry.code = mck_pkg::digit_code(digit_off[3:0]);
    end else if (in_tdata >= mck_pkg::ASCII_LOW_A && in_tdata <= mck_pkg::ASCII_LOW_Z) begin
      q_entry.kind = mck_pkg::KIND_CODE;
      q_entry.code = mck_pkg::letter_code(letter_off[4:0]);
    end else if (in_tdata == mck_pkg::ASCII_SPACE) begin
      q_entry.kind = mck_pkg::KIND_SPACE;
    end
  end

  assign in_tready = q_ready;
  assign q_push    = in_tvalid & q_ready;

endmodule

[design/mck_queue.sv]
// two-entry queue between the classifier and the segment sequencer
module mck_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mck_pkg::entry_t push_entry,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output mck_pkg::entry_t head
);

  mck_pkg::entry_t slot_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign ready = (count_r != 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/mck_back.sv]
// back end: walks a code byte, one key segment per cycle unless stalled
module mck_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  mck_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // [0] key_on, [3:1] units, [7:4] zero
  output logic            out_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_GAP
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] code_r, code_nxt;
  logic       valid_r, valid_nxt;
  logic       key_on_r, key_on_nxt;
  logic [2:0] units_r, units_nxt;
  logic       last_r, last_nxt;
  logic       slot_free;
  logic       final_gap;

  assign slot_free = ~valid_r | out_tready;
  assign final_gap = (code_r == mck_pkg::CODE_END);
  assign q_pop     = (state_r == ST_IDLE) & slot_free & q_valid;

  always_comb begin
    state_nxt  = state_r;
    code_nxt   = code_r;
    valid_nxt  = valid_r & ~out_tready;
    key_on_nxt = key_on_r;
    units_nxt  = units_r;
    last_nxt   = last_r;
    if (slot_free) begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            valid_nxt = 1'b1;
            unique case (q_head.kind)
              mck_pkg::KIND_CODE: begin
                // first dot or dash straight from the queue head
                key_on_nxt = 1'b1;
                units_nxt  = q_head.code[7] ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS;
                last_nxt   = 1'b0;
                code_nxt   = {q_head.code[6:0], 1'b0};
                state_nxt  = ST_GAP;
              end
              mck_pkg::KIND_SPACE: begin
                key_on_nxt = 1'b0;
                units_nxt  = mck_pkg::WORD_GAP;
                last_nxt   = 1'b1;
              end
              default: begin
                key_on_nxt = 1'b0;
                units_nxt  = mck_pkg::OTHER_GAP;
                last_nxt   = 1'b1;
              end
            endcase
          end
        end
        ST_MARK: begin
          valid_nxt  = 1'b1;
          key_on_nxt = 1'b1;
          units_nxt  = code_r[7] ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS;
          last_nxt   = 1'b0;
          code_nxt   = {code_r[6:0], 1'b0};
          state_nxt  = ST_GAP;
        end
        ST_GAP: begin
          valid_nxt  = 1'b1;
          key_on_nxt = 1'b0;
          units_nxt  = final_gap ? mck_pkg::CHAR_GAP : mck_pkg::ELEM_GAP;
          last_nxt   = final_gap;
          state_nxt  = final_gap ? ST_IDLE : ST_MARK;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    code_r   <= code_nxt;
    key_on_r <= key_on_nxt;
    units_r  <= units_nxt;
    last_r   <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0000, units_r, key_on_r};
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  // a mark is never the closing segment of a character
  a_mark_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && key_on_r |-> !last_r)
    else $error("mark segment flagged as last");

  // marks are dots or dashes only
  a_mark_units: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && key_on_r |-> (units_r == mck_pkg::DOT_UNITS || units_r == mck_pkg::DASH_UNITS))
    else $error("mark segment with bad length");

  // a pending mark still has elements left before the end marker
  a_mark_has_element: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MARK |-> (code_r != mck_pkg::CODE_END && code_r != 8'h00))
    else $error("mark state with no element left");

  // every emitted mark is followed by the gap state
  a_mark_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    slot_free && state_r == ST_MARK |=> state_r == ST_GAP)
    else $error("mark not followed by gap");
`endif

endmodule

[design/morse_character_keyer.sv]
// top level of the morse character keyer
//
// Takes one ASCII character per item on the in_ stream and emits the Morse
// key segments for it on the out_ stream, one segment per item: key level in
// out_tdata[0], length in dot units in out_tdata[3:1], and out_tlast high on
// the final segment of the character. Digits and lower-case letters become a
// dot (1 unit) or dash (3 units) followed by a 2 unit gap for each element,
// with the gap after the last element stretched to 5 units. A space gives a
// single 7 unit gap and any other code a single 3 unit gap. The front end
// classifies the character and looks up its code byte in a fixed table; a
// two-entry queue holds classified characters so input can keep flowing
// while the sequencer works. The sequencer emits one segment per cycle into
// an output register while the output side does not stall. A space or
// unsupported code gives one segment, each dot or dash element gives two (a
// mark and a gap), so a digit gives ten segments. No state carries over
// between characters.
module morse_character_keyer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] key_on, [3:1] units, [7:4] zero
  output logic       out_tlast
);

  // classified characters flowing from front end to sequencer
  mck_pkg::entry_t push_entry;
  mck_pkg::entry_t head_entry;
  logic            q_push;
  logic            q_ready;
  logic            q_pop;
  logic            q_valid;

  mck_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  mck_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head_entry)
  );

  // sequencer walks the code byte msb first until only the end marker remains
  mck_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (head_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[sim/tb_top.sv]
// self-checking testbench for the morse character keyer
`timescale 1ns / 100ps

module tb_top;

  // one key segment as it appears on the result stream
  typedef struct packed {
    logic       key_on;
    logic [2:0] units;
    logic       last;
  } segment_t;

  // cycles with no item moving on either side before the run is called hung
  localparam int HANG_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 310;
  // quiet cycles after the last segment, to catch anything extra coming out
  localparam int TAIL_CYCLES  = 30;

  // expected segment store plus the keying predictor
  class segment_scoreboard;
    segment_t   want_q[$];
    int         errors;
    logic [7:0] digit_tbl[10];
    logic [7:0] letter_tbl[26];

    function new();
      errors = 0;
      // code bytes: elements msb first, then a single marker one bit
      digit_tbl  = '{8'hfc, 8'h7c, 8'h3c, 8'h1c, 8'h0c, 8'h04, 8'h84, 8'hc4, 8'he4, 8'hf4};
      letter_tbl = '{8'h60, 8'h88, 8'ha8, 8'h90, 8'h40, 8'h28, 8'hd0, 8'h08, 8'h20,
                     8'h78, 8'hb0, 8'h48, 8'he0, 8'ha0, 8'hf0, 8'h68, 8'hd8, 8'h50,
                     8'h10, 8'hc0, 8'h30, 8'h18, 8'h70, 8'h98, 8'hb8, 8'hc8};
    endfunction

    function void push_seg(logic key_on, logic [2:0] units, logic last);
      segment_t s;
      s.key_on = key_on;
      s.units  = units;
      s.last   = last;
      want_q.push_back(s);
    endfunction

    // expand one accepted character into its key segments
    function void note_char(logic [7:0] ch);
      logic [7:0] code;
      logic [7:0] nxt;
      logic       fin;
      int         i;
      if (ch >= mck_pkg::ASCII_ZERO && ch <= mck_pkg::ASCII_NINE) begin
        code = digit_tbl[int'(ch - mck_pkg::ASCII_ZERO)];
      end else if (ch >= mck_pkg::ASCII_LOW_A && ch <= mck_pkg::ASCII_LOW_Z) begin
        code = letter_tbl[int'(ch - mck_pkg::ASCII_LOW_A)];
      end else if (ch == mck_pkg::ASCII_SPACE) begin
        push_seg(1'b0, mck_pkg::WORD_GAP, 1'b1);
        return;
      end else begin
        push_seg(1'b0, mck_pkg::OTHER_GAP, 1'b1);
        return;
      end
      for (i = 0; i < 8 && code != mck_pkg::CODE_END; i++) begin
        nxt = code << 1;
        fin = (nxt == mck_pkg::CODE_END);
        // mark: dash on a one, dot on a zero
        push_seg(1'b1, code[7] ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS, 1'b0);
        // gap: element gap, stretched on the final element
        push_seg(1'b0, fin ? mck_pkg::CHAR_GAP : mck_pkg::ELEM_GAP, fin);
        code = nxt;
      end
    endfunction

    function void check_seg(logic key_on, logic [2:0] units, logic last, logic [3:0] pad);
      segment_t w;
      if (want_q.size() == 0) begin
        $error("unexpected segment: key_on %0d units %0d last %0d", key_on, units, last);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (key_on !== w.key_on) begin
        $error("key_on mismatch: expected %0d, actual %0d", w.key_on, key_on);
        errors++;
      end
      if (units !== w.units) begin
        $error("units mismatch: expected %0d, actual %0d", w.units, units);
        errors++;
      end
      if (last !== w.last) begin
        $error("last mismatch: expected %0d, actual %0d", w.last, last);
        errors++;
      end
      if (pad !== 4'd0) begin
        $error("tdata pad mismatch: expected 0, actual %0d", pad);
        errors++;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  // clock, reset and all block inputs start at known values
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] character
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [0] key_on, [3:1] units, [7:4] zero
  logic       out_tlast;

  // idle chances in percent per cycle, changed from phase to phase
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  segment_scoreboard sb = new();

  morse_character_keyer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // result side: every accepted segment goes straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_seg(out_tdata[0], out_tdata[3:1], out_tlast, out_tdata[7:4]);
    end
  end

  // result side backpressure: random stall bursts
  always begin
    @(posedge clk);
    if (rst_n && $urandom_range(0, 99) < out_idle_pct) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  // hang detection: any accepted item on either side restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  // present one character and hold it until the block takes it
  task automatic send_char(input logic [7:0] ch);
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    sb.note_char(ch);
  endtask

  // after an item, maybe drop valid for a random burst
  task automatic maybe_gap();
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // hold off input until every outstanding segment has come out
  task automatic drain_segments();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly real morse characters, some arbitrary byte noise
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return mck_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
    if (r < 75) return mck_pkg::ASCII_LOW_A + 8'($urandom_range(0, 25));
    if (r < 85) return mck_pkg::ASCII_SPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  // edge characters: table ends, neighbors of each range, byte extremes,
  // single-element letters, all-dot and all-dash digits, space
  logic [7:0] directed_chars[] = '{
    8'h30, 8'h39, 8'h61, 8'h7a, 8'h20, 8'h00, 8'hff, 8'h41, 8'h5a, 8'h2f,
    8'h3a, 8'h60, 8'h7b, 8'h7f, 8'h80, 8'h65, 8'h74, 8'h35, 8'h71, 8'h79,
    8'h1f, 8'h21, 8'h36
  };

  initial begin
    int n;
    // synchronous reset, held low before release
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with light idling on both sides
    in_idle_pct  = 20;
    out_idle_pct = 20;
    foreach (directed_chars[k]) begin
      send_char(directed_chars[k]);
      maybe_gap();
    end
    // sender waits for the block to empty completely
    drain_segments();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        in_idle_pct  = 30;
        out_idle_pct = 30;
      end else if (n == 100) begin
        drain_segments();
        // heavy output backpressure, input never idles
        in_idle_pct  = 0;
        out_idle_pct = 50;
      end else if (n == 180) begin
        // slow sender, output always ready
        in_idle_pct  = 60;
        out_idle_pct = 0;
      end else if (n == 240) begin
        // closing stretch with no idling anywhere
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      send_char(pick_char());
      maybe_gap();
    end

    drain_segments();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
